FILE: hdl/biou_pkg.sv
package biou_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int FRACTION_BITS_DEF = 16;

    typedef struct packed {
        logic valid;
        logic bad;
    } biou_tag_t;

endpackage

FILE: hdl/box_intersection_over_union_core.sv
// Computes intersection over union of two boxes with inclusive pixel corners and takes one
// box pair per clock cycle while the result stream is not stalled. Registered stages find
// the side lengths, the areas and the union in turn, and a row of FRACTION_BITS + 1
// division cells then produces one quotient bit each. Either stream may stall at any time;
// every stage holds its own transaction, so empty stages keep taking input while a result
// waits.
module box_intersection_over_union_core #(
    parameter int COORD_BITS    = biou_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = biou_pkg::FRACTION_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // box_a_left, box_a_top, box_a_right, box_a_bottom,
    // box_b_left, box_b_top, box_b_right, box_b_bottom
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]            s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // overlap_ratio
    output logic [((FRACTION_BITS+1+7)/8)*8-1:0]         m_tdata,
    // bad_box
    output logic                                         m_tuser
);
    import biou_pkg::*;

    localparam int AREA_W = 2 * COORD_BITS + 1;
    localparam int QUO_W  = FRACTION_BITS + 1;
    localparam int NCELL  = FRACTION_BITS + 1;
    localparam int M_W    = ((FRACTION_BITS + 1 + 7) / 8) * 8;

    biou_tag_t         tag_w [0:NCELL];
    logic              rdy_w [0:NCELL];
    logic [AREA_W:0]   rem_w [0:NCELL];
    logic [AREA_W-1:0] div_w [0:NCELL];
    logic [QUO_W-1:0]  quo_w [0:NCELL];
    logic [AREA_W-1:0] inter;

    biou_prep #(
        .COORD_BITS(COORD_BITS)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_boxes  (s_tdata[8*COORD_BITS-1:0]),
        .tag_out   (tag_w[0]),
        .out_ready (rdy_w[0]),
        .inter_out (inter),
        .uni_out   (div_w[0])
    );

    assign rem_w[0] = {1'b0, inter};
    assign quo_w[0] = '0;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        biou_div_cell #(
            .AREA_W(AREA_W),
            .QUO_W (QUO_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tag_in    (tag_w[i]),
            .in_ready  (rdy_w[i]),
            .rem_in    (rem_w[i]),
            .div_in    (div_w[i]),
            .quo_in    (quo_w[i]),
            .tag_out   (tag_w[i+1]),
            .out_ready (rdy_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .div_out   (div_w[i+1]),
            .quo_out   (quo_w[i+1])
        );
    end

    assign rdy_w[NCELL] = m_tready;
    assign m_tvalid     = tag_w[NCELL].valid;
    assign m_tuser      = tag_w[NCELL].bad;
    assign m_tdata      = M_W'(quo_w[NCELL]);

endmodule

FILE: hdl/biou_prep.sv
module biou_prep #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [8*COORD_BITS-1:0]     in_boxes,
    output biou_pkg::biou_tag_t         tag_out,
    input  logic                        out_ready,
    output logic [2*COORD_BITS:0]       inter_out,
    output logic [2*COORD_BITS:0]       uni_out
);
    import biou_pkg::*;

    localparam int SIDE_W = COORD_BITS + 1;
    localparam int AREA_W = 2 * COORD_BITS + 1;

    logic [COORD_BITS-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic [COORD_BITS-1:0] max_l, max_t, min_r, min_b;
    logic                  bad, disjoint;

    biou_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg;
    biou_tag_t s1_tag_next, s2_tag_next, s3_tag_next;
    logic      s1_ready, s2_ready, s3_ready;

    logic [SIDE_W-1:0] a_w_reg, a_h_reg, b_w_reg, b_h_reg, i_w_reg, i_h_reg;
    logic [SIDE_W-1:0] a_w_next, a_h_next, b_w_next, b_h_next, i_w_next, i_h_next;
    logic              s1_zero_reg, s2_zero_reg;

    logic [2*SIDE_W-1:0] prod_a, prod_b, prod_i;
    logic [AREA_W-1:0]   area_a_reg, area_b_reg, inter2_reg;
    logic [AREA_W-1:0]   area_a_next, area_b_next, inter2_next;

    logic [AREA_W:0]     uni_sum;
    logic [AREA_W-1:0]   inter3_reg, uni3_reg;
    logic [AREA_W-1:0]   inter3_next, uni3_next;

    assign al = in_boxes[0*COORD_BITS +: COORD_BITS];
    assign at = in_boxes[1*COORD_BITS +: COORD_BITS];
    assign ar = in_boxes[2*COORD_BITS +: COORD_BITS];
    assign ab = in_boxes[3*COORD_BITS +: COORD_BITS];
    assign bl = in_boxes[4*COORD_BITS +: COORD_BITS];
    assign bt = in_boxes[5*COORD_BITS +: COORD_BITS];
    assign br = in_boxes[6*COORD_BITS +: COORD_BITS];
    assign bb = in_boxes[7*COORD_BITS +: COORD_BITS];

    assign s3_ready = !s3_tag_reg.valid || out_ready;
    assign s2_ready = !s2_tag_reg.valid || s3_ready;
    assign s1_ready = !s1_tag_reg.valid || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        bad      = (ar < al) || (ab < at) || (br < bl) || (bb < bt);
        disjoint = (al > br) || (at > bb) || (ar < bl) || (ab < bt);
        max_l    = (al > bl) ? al : bl;
        max_t    = (at > bt) ? at : bt;
        min_r    = (ar < br) ? ar : br;
        min_b    = (ab < bb) ? ab : bb;
        a_w_next = SIDE_W'(ar) - SIDE_W'(al) + SIDE_W'(1);
        a_h_next = SIDE_W'(ab) - SIDE_W'(at) + SIDE_W'(1);
        b_w_next = SIDE_W'(br) - SIDE_W'(bl) + SIDE_W'(1);
        b_h_next = SIDE_W'(bb) - SIDE_W'(bt) + SIDE_W'(1);
        i_w_next = SIDE_W'(min_r) - SIDE_W'(max_l) + SIDE_W'(1);
        i_h_next = SIDE_W'(min_b) - SIDE_W'(max_t) + SIDE_W'(1);
    end

    always_comb begin
        prod_a      = (2*SIDE_W)'(a_w_reg) * (2*SIDE_W)'(a_h_reg);
        prod_b      = (2*SIDE_W)'(b_w_reg) * (2*SIDE_W)'(b_h_reg);
        prod_i      = (2*SIDE_W)'(i_w_reg) * (2*SIDE_W)'(i_h_reg);
        area_a_next = prod_a[AREA_W-1:0];
        area_b_next = prod_b[AREA_W-1:0];
        inter2_next = s1_zero_reg ? '0 : prod_i[AREA_W-1:0];
    end

    always_comb begin
        uni_sum     = {1'b0, area_a_reg} + {1'b0, area_b_reg} - {1'b0, inter2_reg};
        inter3_next = inter2_reg;
        uni3_next   = s2_zero_reg ? AREA_W'(1) : uni_sum[AREA_W-1:0];
    end

    always_comb begin
        s1_tag_next = s1_tag_reg;
        s2_tag_next = s2_tag_reg;
        s3_tag_next = s3_tag_reg;
        if (s1_ready) begin
            s1_tag_next.valid = in_valid;
            s1_tag_next.bad   = bad;
        end
        if (s2_ready) begin
            s2_tag_next = s1_tag_reg;
        end
        if (s3_ready) begin
            s3_tag_next = s2_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end else begin
            s1_tag_reg <= s1_tag_next;
            s2_tag_reg <= s2_tag_next;
            s3_tag_reg <= s3_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            a_w_reg     <= a_w_next;
            a_h_reg     <= a_h_next;
            b_w_reg     <= b_w_next;
            b_h_reg     <= b_h_next;
            i_w_reg     <= i_w_next;
            i_h_reg     <= i_h_next;
            s1_zero_reg <= bad || disjoint;
        end
        if (s2_ready) begin
            area_a_reg  <= area_a_next;
            area_b_reg  <= area_b_next;
            inter2_reg  <= inter2_next;
            s2_zero_reg <= s1_zero_reg;
        end
        if (s3_ready) begin
            inter3_reg <= inter3_next;
            uni3_reg   <= uni3_next;
        end
    end

    assign tag_out   = s3_tag_reg;
    assign inter_out = inter3_reg;
    assign uni_out   = uni3_reg;

endmodule

FILE: hdl/biou_div_cell.sv
module biou_div_cell #(
    parameter int AREA_W = 2 * biou_pkg::COORD_BITS_DEF + 1,
    parameter int QUO_W  = biou_pkg::FRACTION_BITS_DEF + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  biou_pkg::biou_tag_t   tag_in,
    output logic                  in_ready,
    input  logic [AREA_W:0]       rem_in,
    input  logic [AREA_W-1:0]     div_in,
    input  logic [QUO_W-1:0]      quo_in,
    output biou_pkg::biou_tag_t   tag_out,
    input  logic                  out_ready,
    output logic [AREA_W:0]       rem_out,
    output logic [AREA_W-1:0]     div_out,
    output logic [QUO_W-1:0]      quo_out
);
    import biou_pkg::*;

    biou_tag_t         tag_reg;
    logic [AREA_W:0]   rem_reg, rem_next;
    logic [AREA_W-1:0] div_reg;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              fits;
    logic [AREA_W:0]   diff;

    assign in_ready = !tag_reg.valid || out_ready;

    always_comb begin
        fits     = rem_in >= {1'b0, div_in};
        diff     = fits ? (rem_in - {1'b0, div_in}) : rem_in;
        rem_next = {diff[AREA_W-1:0], 1'b0};
        quo_next = {quo_in[QUO_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (in_ready) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg <= rem_next;
            div_reg <= div_in;
            quo_reg <= quo_next;
        end
    end

    assign tag_out = tag_reg;
    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign quo_out = quo_reg;

endmodule

FILE: hdl/biou_checker.sv
module biou_checker #(
    parameter int FRACTION_BITS = biou_pkg::FRACTION_BITS_DEF
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((FRACTION_BITS+1+7)/8)*8-1:0]  m_tdata,
    input logic                                  m_tuser
);
    localparam int M_W = ((FRACTION_BITS + 1 + 7) / 8) * 8;
    localparam logic [M_W-1:0] ONE = M_W'(1) << FRACTION_BITS;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("inverted box gave a nonzero ratio");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= ONE)
        else $error("ratio above one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transaction changed");

endmodule

bind box_intersection_over_union_core biou_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_biou_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
